@@ rtl/acc_pkg.sv @@
// ----------------------------------------------------------------------------
// acc_pkg
// Shared types, constants and helpers of the axis convention converter:
// lane control words, coefficient codes and saturating helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package acc_pkg;

   localparam int LANES     = 9;
   localparam int LIN_LANES = 5;
   localparam int SH_COEFFS = 24;
   localparam int VALUE_W   = 32;
   localparam int PROD_W    = 64;

   // operation codes
   localparam logic [1:0] OP_POSITION   = 2'd0;
   localparam logic [1:0] OP_QUATERNION = 2'd1;
   localparam logic [1:0] OP_SH_BAND    = 2'd2;

   // register indexes
   localparam logic [1:0] CSR_FROM_SYSTEM = 2'd0;
   localparam logic [1:0] CSR_TO_SYSTEM   = 2'd1;
   localparam logic [1:0] CSR_SH_DEGREE   = 2'd2;
   localparam logic [1:0] CSR_COEFF_COUNT = 2'd3;

   // Q1.30 coefficients
   localparam logic signed [31:0] C_S2   = 32'sd759250125;
   localparam logic signed [31:0] C_S3H  = 32'sd929887697;
   localparam logic signed [31:0] C_HALF = 32'sd536870912;

   localparam logic signed [31:0] VALUE_MAX = 32'sh7fffffff;
   localparam logic signed [31:0] VALUE_MIN = 32'sh80000000;

   // sign mask per sh coefficient: bit0 x, bit1 y, bit2 z
   localparam logic [2:0] SH_SIGN_MASK [SH_COEFFS] = '{
      3'd2, 3'd4, 3'd1, 3'd3, 3'd6, 3'd0, 3'd5, 3'd0, 3'd2, 3'd7, 3'd2, 3'd4,
      3'd1, 3'd4, 3'd1, 3'd3, 3'd6, 3'd3, 3'd6, 3'd0, 3'd5, 3'd0, 3'd5, 3'd2
   };

   typedef logic signed [VALUE_W-1:0] value_type;

   typedef enum logic [1:0] {
      LANE_ZERO,
      LANE_PASS,
      LANE_LIN
   } lane_kind_type;

   typedef enum logic [2:0] {
      COEF_S2,
      COEF_NS2,
      COEF_S3H,
      COEF_NS3H,
      COEF_HALF,
      COEF_NHALF
   } coef_type;

   typedef struct packed {
      lane_kind_type kind;
      logic [3:0]    sel_a;
      logic          neg_a;
      coef_type      coef_a;
      logic [3:0]    sel_b;
      logic          neg_b;
      coef_type      coef_b;
      logic          post_neg;
   } lane_ctl_type;

   typedef struct packed {
      value_type    [LANES-1:0] value;
      lane_ctl_type [LANES-1:0] lane;
   } entry_type;

   function automatic value_type coef_value(input coef_type c);
      value_type v;
      unique case (c)
         COEF_S2:    v = C_S2;
         COEF_NS2:   v = -C_S2;
         COEF_S3H:   v = C_S3H;
         COEF_NS3H:  v = -C_S3H;
         COEF_HALF:  v = C_HALF;
         COEF_NHALF: v = -C_HALF;
         default:    v = '0;
      endcase
      return v;
   endfunction

   function automatic value_type neg_sat(input value_type x);
      return (x == VALUE_MIN) ? VALUE_MAX : -x;
   endfunction

   function automatic logic parity3(input logic [2:0] m);
      return m[0] ^ m[1] ^ m[2];
   endfunction

endpackage

`default_nettype wire

@@ rtl/axis_convention_converter_unit.sv @@
// path: a pushed item passes the queue, stage one and the result register in turn
// throughput: one item per cycle unless full; the back pipeline moves whenever
// the result register is free or being popped, the queue absorbs result-side stalls
// reset: synchronous; empties the queue and pipeline and loads the register
// defaults (codes 0, degree 0, coefficient count 24); no clearing pass
// ----------------------------------------------------------------------------
// axis_convention_converter_unit
// Top level: classifying front, item queue and arithmetic back.
// ----------------------------------------------------------------------------
`default_nettype none

module axis_convention_converter_unit import acc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        valid,
   output logic             ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data,
   // items in
   input  wire logic        push,
   output logic             full,
   input  wire logic [1:0]  req_operation,
   input  wire logic [1:0]  req_band,
   input  wire value_type   req_value_0,
   input  wire value_type   req_value_1,
   input  wire value_type   req_value_2,
   input  wire value_type   req_value_3,
   input  wire value_type   req_value_4,
   input  wire value_type   req_value_5,
   input  wire value_type   req_value_6,
   input  wire value_type   req_value_7,
   input  wire value_type   req_value_8,
   // results out
   output logic             empty,
   input  wire logic        pop,
   output value_type        rsp_result_0,
   output value_type        rsp_result_1,
   output value_type        rsp_result_2,
   output value_type        rsp_result_3,
   output value_type        rsp_result_4,
   output value_type        rsp_result_5,
   output value_type        rsp_result_6,
   output value_type        rsp_result_7,
   output value_type        rsp_result_8
);

   value_type req_value [LANES];
   value_type result [LANES];
   logic      wr_en, rd_en, nonempty;
   entry_type wr_entry, head;

   assign req_value[0] = req_value_0;
   assign req_value[1] = req_value_1;
   assign req_value[2] = req_value_2;
   assign req_value[3] = req_value_3;
   assign req_value[4] = req_value_4;
   assign req_value[5] = req_value_5;
   assign req_value[6] = req_value_6;
   assign req_value[7] = req_value_7;
   assign req_value[8] = req_value_8;

   acc_front u_front (
      .clock         (clock),
      .reset         (reset),
      .valid         (valid),
      .ready         (ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_band      (req_band),
      .req_value     (req_value),
      .wr_en         (wr_en),
      .wr_entry      (wr_entry)
   );

   acc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_entry (wr_entry),
      .rd_en    (rd_en),
      .rd_entry (head),
      .nonempty (nonempty),
      .full     (full)
   );

   acc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (nonempty),
      .head       (head),
      .rd_en      (rd_en),
      .empty      (empty),
      .pop        (pop),
      .result     (result)
   );

   assign rsp_result_0 = result[0];
   assign rsp_result_1 = result[1];
   assign rsp_result_2 = result[2];
   assign rsp_result_3 = result[3];
   assign rsp_result_4 = result[4];
   assign rsp_result_5 = result[5];
   assign rsp_result_6 = result[6];
   assign rsp_result_7 = result[7];
   assign rsp_result_8 = result[8];

endmodule

`default_nettype wire

@@ rtl/acc_front.sv @@
// ----------------------------------------------------------------------------
// acc_front
// Holds the convention registers, accepts items and turns each one into a
// per-lane control word (source, pre-negate, coefficient, post-negate).
// ----------------------------------------------------------------------------
`default_nettype none

module acc_front import acc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        valid,
   output logic             ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [4:0]  csr_data,
   // items
   input  wire logic        push,
   input  wire logic        full,
   input  wire logic [1:0]  req_operation,
   input  wire logic [1:0]  req_band,
   input  wire value_type   req_value [LANES],
   output logic             wr_en,
   output entry_type        wr_entry
);

   typedef struct packed {
      logic [4:0] from_system;
      logic [4:0] to_system;
      logic [2:0] sh_degree;
      logic [4:0] coeff_count;
   } csr_type;

   localparam logic [4:0] COUNT_RESET = 5'd24;
   localparam logic [4:0] COUNT_CAP   = 5'(SH_COEFFS);

   csr_type cfg_ff, cfg_in;

   logic       ident, rot, back;
   logic [2:0] mis;
   logic [2:0] fl;
   logic [4:0] from_m1, to_m1, cnt;
   logic [1:0] lim;
   logic [4:0] start;
   logic [3:0] size;
   logic [4:0] idx;
   logic       in_reach;

   function automatic lane_ctl_type zero_lane(input logic [3:0] sel);
      lane_ctl_type l;
      l.kind     = LANE_ZERO;
      l.sel_a    = sel;
      l.neg_a    = 1'b0;
      l.coef_a   = COEF_S2;
      l.sel_b    = sel;
      l.neg_b    = 1'b0;
      l.coef_b   = COEF_S2;
      l.post_neg = 1'b0;
      return l;
   endfunction

   function automatic lane_ctl_type pass_lane(input logic [3:0] sel, input logic pre,
                                              input logic post);
      lane_ctl_type l;
      l          = zero_lane(sel);
      l.kind     = LANE_PASS;
      l.neg_a    = pre;
      l.post_neg = post;
      return l;
   endfunction

   function automatic lane_ctl_type lin_lane(input logic [3:0] sa, input logic na,
                                             input coef_type ca, input logic [3:0] sb,
                                             input logic nb, input coef_type cb,
                                             input logic post);
      lane_ctl_type l;
      l.kind     = LANE_LIN;
      l.sel_a    = sa;
      l.neg_a    = na;
      l.coef_a   = ca;
      l.sel_b    = sb;
      l.neg_b    = nb;
      l.coef_b   = cb;
      l.post_neg = post;
      return l;
   endfunction

   assign ready = 1'b1;
   assign wr_en = push && !full;

   always_comb begin
      cfg_in = cfg_ff;
      if (valid) begin
         unique case (csr_index)
            CSR_FROM_SYSTEM: cfg_in.from_system = csr_data;
            CSR_TO_SYSTEM:   cfg_in.to_system   = csr_data;
            CSR_SH_DEGREE:   cfg_in.sh_degree   = csr_data[2:0];
            CSR_COEFF_COUNT: cfg_in.coeff_count = csr_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.from_system <= '0;
         cfg_ff.to_system   <= '0;
         cfg_ff.sh_degree   <= '0;
         cfg_ff.coeff_count <= COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      from_m1 = cfg_ff.from_system - 5'd1;
      to_m1   = cfg_ff.to_system - 5'd1;
      ident   = (cfg_ff.from_system == cfg_ff.to_system) || (cfg_ff.from_system == 5'd0)
                || (cfg_ff.to_system == 5'd0);
      mis     = ident ? 3'd0 : (from_m1[2:0] ^ to_m1[2:0]);
      rot     = !ident && (from_m1[3] ^ to_m1[3]);
      back    = !ident && from_m1[3];
      // quaternion flips: each axis flips with the other two
      fl[0]   = mis[1] ^ mis[2];
      fl[1]   = mis[0] ^ mis[2];
      fl[2]   = mis[0] ^ mis[1];
      cnt     = (cfg_ff.coeff_count < COUNT_CAP) ? cfg_ff.coeff_count : COUNT_CAP;
      lim     = (cfg_ff.sh_degree < 3'd2) ? cfg_ff.sh_degree[1:0] : 2'd2;

      unique case (req_band)
         2'd0:    begin start = 5'd0;  size = 4'd3; end
         2'd1:    begin start = 5'd3;  size = 4'd5; end
         2'd2:    begin start = 5'd8;  size = 4'd7; end
         default: begin start = 5'd15; size = 4'd9; end
      endcase
      in_reach = (req_band < lim) && ((6'(start) + 6'(size)) <= 6'(cnt));

      for (int k = 0; k < LANES; k++) begin
         wr_entry.value[k] = req_value[k];
         wr_entry.lane[k]  = zero_lane(4'(k));
      end
      idx = '0;

      unique case (req_operation)
         OP_POSITION: begin
            if (rot && !back) begin
               wr_entry.lane[0] = pass_lane(4'd0, 1'b0, mis[0]);
               wr_entry.lane[1] = pass_lane(4'd2, 1'b1, mis[1]);
               wr_entry.lane[2] = pass_lane(4'd1, 1'b0, mis[2]);
            end else if (rot && back) begin
               wr_entry.lane[0] = pass_lane(4'd0, 1'b0, mis[0]);
               wr_entry.lane[1] = pass_lane(4'd2, mis[2], 1'b0);
               wr_entry.lane[2] = pass_lane(4'd1, mis[1], 1'b1);
            end else begin
               for (int k = 0; k < 3; k++) begin
                  wr_entry.lane[k] = pass_lane(4'(k), 1'b0, mis[k]);
               end
            end
         end
         OP_QUATERNION: begin
            if (rot && !back) begin
               wr_entry.lane[0] = lin_lane(4'd0, 1'b0, COEF_S2, 4'd1, 1'b0, COEF_S2, fl[0]);
               wr_entry.lane[1] = lin_lane(4'd2, 1'b0, COEF_S2, 4'd3, 1'b0, COEF_NS2, fl[1]);
               wr_entry.lane[2] = lin_lane(4'd2, 1'b0, COEF_S2, 4'd3, 1'b0, COEF_S2, fl[2]);
               wr_entry.lane[3] = lin_lane(4'd0, 1'b0, COEF_S2, 4'd1, 1'b0, COEF_NS2, 1'b0);
            end else if (rot && back) begin
               wr_entry.lane[0] = lin_lane(4'd0, fl[0], COEF_NS2, 4'd1, fl[1], COEF_S2, 1'b0);
               wr_entry.lane[1] = lin_lane(4'd2, fl[2], COEF_S2, 4'd3, 1'b0, COEF_S2, 1'b0);
               wr_entry.lane[2] = lin_lane(4'd2, fl[2], COEF_NS2, 4'd3, 1'b0, COEF_S2, 1'b0);
               wr_entry.lane[3] = lin_lane(4'd0, fl[0], COEF_S2, 4'd1, fl[1], COEF_S2, 1'b0);
            end else begin
               for (int k = 0; k < 3; k++) begin
                  wr_entry.lane[k] = pass_lane(4'(k), 1'b0, fl[k]);
               end
               wr_entry.lane[3] = pass_lane(4'd3, 1'b0, 1'b0);
            end
         end
         OP_SH_BAND: begin
            for (int k = 0; k < LANES; k++) begin
               idx = start + 5'(k);
               if (4'(k) < size) begin
                  wr_entry.lane[k] = pass_lane(4'(k), 1'b0,
                     !rot && (idx < cnt) && parity3(SH_SIGN_MASK[idx] & mis));
               end
            end
            if (rot && in_reach) begin
               if (req_band == 2'd0) begin
                  wr_entry.lane[0] = pass_lane(4'd1, 1'b0, back);
                  wr_entry.lane[1] = pass_lane(4'd0, 1'b0, !back);
               end else begin
                  wr_entry.lane[0] = pass_lane(4'd3, 1'b0, back);
                  wr_entry.lane[1] = pass_lane(4'd1, 1'b0, 1'b1);
                  wr_entry.lane[2] = lin_lane(4'd2, 1'b0, COEF_NHALF, 4'd4, 1'b0, COEF_NS3H,
                                              1'b0);
                  wr_entry.lane[3] = pass_lane(4'd0, 1'b0, !back);
                  wr_entry.lane[4] = lin_lane(4'd2, 1'b0, COEF_NS3H, 4'd4, 1'b0, COEF_HALF,
                                              1'b0);
               end
            end
         end
         default: begin
            // unused operation: all lanes stay zero
         end
      endcase
   end

endmodule

`default_nettype wire

@@ rtl/acc_queue.sv @@
// ----------------------------------------------------------------------------
// acc_queue
// Short queue of classified items between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_queue import acc_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire entry_type wr_entry,
   input  wire logic      rd_en,
   output entry_type      rd_entry,
   output logic           nonempty,
   output logic           full
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST  = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] LIMIT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == LIMIT);
   assign nonempty = (count_ff != '0);
   assign rd_entry = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && nonempty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule

`default_nettype wire

@@ rtl/acc_back.sv @@
// ----------------------------------------------------------------------------
// acc_back
// Executes classified items: operand select and pre-negate with constant
// multiplies, then sum, round, saturate and post-negate into the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_back import acc_pkg::*; (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      head_valid,
   input  wire entry_type head,
   output logic           rd_en,
   output logic           empty,
   input  wire logic      pop,
   output value_type      result [LANES]
);

   localparam logic signed [PROD_W-1:0] ROUND_BIAS = 64'sd536870912;
   localparam logic signed [PROD_W-1:0] SAT_MAX    = 64'(VALUE_MAX);
   localparam logic signed [PROD_W-1:0] SAT_MIN    = 64'(VALUE_MIN);

   logic                      s1_valid_ff, s1_valid_in;
   logic                      s2_valid_ff, s2_valid_in;
   logic                      s1_load, s2_load;

   logic signed [PROD_W-1:0]  s1_prod_a_ff [LIN_LANES];
   logic signed [PROD_W-1:0]  s1_prod_b_ff [LIN_LANES];
   logic signed [PROD_W-1:0]  s1_prod_a_in [LIN_LANES];
   logic signed [PROD_W-1:0]  s1_prod_b_in [LIN_LANES];
   value_type                 s1_pass_ff [LANES];
   value_type                 s1_pass_in [LANES];
   lane_kind_type             s1_kind_ff [LANES];
   logic                      s1_post_ff [LANES];
   value_type                 s2_result_ff [LANES];
   value_type                 s2_result_in [LANES];

   value_type                 opnd_a [LANES];
   value_type                 opnd_b [LIN_LANES];
   logic signed [PROD_W-1:0]  sum [LIN_LANES];
   logic signed [PROD_W-1:0]  rounded [LIN_LANES];
   value_type                 lin_val [LIN_LANES];
   value_type                 pre_post [LANES];

   assign s2_load = !s2_valid_ff || pop;
   assign s1_load = !s1_valid_ff || s2_load;
   assign rd_en   = head_valid && s1_load;
   assign empty   = !s2_valid_ff;

   assign s1_valid_in = s1_load ? head_valid : s1_valid_ff;
   assign s2_valid_in = s2_load ? s1_valid_ff : s2_valid_ff;

   // operand select and constant multiply
   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         opnd_a[k] = head.value[head.lane[k].sel_a];
         if (head.lane[k].neg_a) begin
            opnd_a[k] = neg_sat(opnd_a[k]);
         end
         s1_pass_in[k] = opnd_a[k];
      end
      for (int k = 0; k < LIN_LANES; k++) begin
         opnd_b[k] = head.value[head.lane[k].sel_b];
         if (head.lane[k].neg_b) begin
            opnd_b[k] = neg_sat(opnd_b[k]);
         end
         s1_prod_a_in[k] = 64'(opnd_a[k]) * 64'(coef_value(head.lane[k].coef_a));
         s1_prod_b_in[k] = 64'(opnd_b[k]) * 64'(coef_value(head.lane[k].coef_b));
      end
   end

   // sum, round to nearest with ties up, saturate
   always_comb begin
      for (int k = 0; k < LIN_LANES; k++) begin
         sum[k]     = s1_prod_a_ff[k] + s1_prod_b_ff[k];
         rounded[k] = (sum[k] + ROUND_BIAS) >>> 30;
         if (rounded[k] > SAT_MAX) begin
            lin_val[k] = VALUE_MAX;
         end else if (rounded[k] < SAT_MIN) begin
            lin_val[k] = VALUE_MIN;
         end else begin
            lin_val[k] = rounded[k][VALUE_W-1:0];
         end
      end
      for (int k = 0; k < LANES; k++) begin
         pre_post[k] = s1_pass_ff[k];
      end
      for (int k = 0; k < LIN_LANES; k++) begin
         if (s1_kind_ff[k] == LANE_LIN) begin
            pre_post[k] = lin_val[k];
         end
      end
      for (int k = 0; k < LANES; k++) begin
         if (s1_kind_ff[k] == LANE_ZERO) begin
            s2_result_in[k] = '0;
         end else if (s1_post_ff[k]) begin
            s2_result_in[k] = neg_sat(pre_post[k]);
         end else begin
            s2_result_in[k] = pre_post[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         for (int k = 0; k < LANES; k++) begin
            s1_pass_ff[k] <= s1_pass_in[k];
            s1_kind_ff[k] <= head.lane[k].kind;
            s1_post_ff[k] <= head.lane[k].post_neg;
         end
         for (int k = 0; k < LIN_LANES; k++) begin
            s1_prod_a_ff[k] <= s1_prod_a_in[k];
            s1_prod_b_ff[k] <= s1_prod_b_in[k];
         end
      end
      if (s2_load) begin
         for (int k = 0; k < LANES; k++) begin
            s2_result_ff[k] <= s2_result_in[k];
         end
      end
   end

   always_comb begin
      for (int k = 0; k < LANES; k++) begin
         result[k] = s2_result_ff[k];
      end
   end

endmodule

`default_nettype wire

@@ rtl/acc_checker.sv @@
// ----------------------------------------------------------------------------
// acc_checker
// Port-level checks of the converter: reset state, held results and the
// count of items in flight against the full and empty flags.
// ----------------------------------------------------------------------------
`default_nettype none

module acc_checker import acc_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input wire logic      clock,
   input wire logic      reset,
   input wire logic      push,
   input wire logic      full,
   input wire logic      empty,
   input wire logic      pop,
   input wire value_type rsp_result_0,
   input wire value_type rsp_result_8
);

   logic [7:0] outstanding_ff, outstanding_in;
   logic       in_take, out_take;

   assign in_take  = push && !full;
   assign out_take = pop && !empty;

   always_comb begin
      outstanding_in = outstanding_ff;
      if (in_take && !out_take) begin
         outstanding_in = outstanding_ff + 8'd1;
      end else if (out_take && !in_take) begin
         outstanding_in = outstanding_ff - 8'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         outstanding_ff <= '0;
      end else begin
         outstanding_ff <= outstanding_in;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> empty && !full)
      else $error("queue not empty after reset");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_result_0) && $stable(rsp_result_8)))
      else $error("waiting result changed");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (outstanding_ff != 8'd0))
      else $error("result shown with no item in flight");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      full |-> (outstanding_ff >= 8'(QUEUE_DEPTH)))
      else $error("full raised with queue not filled");

endmodule

bind axis_convention_converter_unit acc_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_acc_checker (
   .clock        (clock),
   .reset        (reset),
   .push         (push),
   .full         (full),
   .empty        (empty),
   .pop          (pop),
   .rsp_result_0 (rsp_result_0),
   .rsp_result_8 (rsp_result_8)
);

`default_nettype wire

@@ tb/sv/tb_axis_convention_converter_unit.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_axis_convention_converter_unit
// Self-checking bench for the axis convention converter. A short table of
// directed items across a set of register settings is followed by random
// phases of items under random register settings. Every popped result is
// compared lane by lane with the bench's own prediction. Items go in bursts
// with random gaps, and pop stalls follow a changing pattern.
// ----------------------------------------------------------------------------

module tb_axis_convention_converter_unit;
   import acc_pkg::*;

   localparam logic [1:0] OP_UNUSED    = 2'd3;
   localparam int         QUIET_LIMIT  = 2000;
   localparam int         RAND_PHASES  = 14;
   localparam int         PHASE_ITEMS  = 125;
   localparam int         SETTLE       = 4;

   localparam logic [31:0] V_MAX  = 32'h7fffffff;
   localparam logic [31:0] V_MIN  = 32'h80000000;
   localparam logic [31:0] V_NEG1 = 32'hffffffff;

   // Q1.30 rotation weights
   localparam longint W_S2   = 759250125;
   localparam longint W_S3H  = 929887697;
   localparam longint W_HALF = 536870912;

   // axes whose flip negates each sh coefficient: bit0 x, bit1 y, bit2 z
   localparam logic [0:23][2:0] COEF_AXES = {
      3'd2, 3'd4, 3'd1, 3'd3, 3'd6, 3'd0, 3'd5, 3'd0, 3'd2, 3'd7, 3'd2, 3'd4,
      3'd1, 3'd4, 3'd1, 3'd3, 3'd6, 3'd3, 3'd6, 3'd0, 3'd5, 3'd0, 3'd5, 3'd2
   };

   typedef logic [8:0][31:0] lane_vec_t;

   typedef struct packed {
      logic [4:0] from_code;
      logic [4:0] to_code;
      logic [2:0] degree;
      logic [4:0] count;
      logic [1:0] op;
      logic [1:0] band;
      lane_vec_t  v;
      bit         known;
      lane_vec_t  want;
   } stim_row_t;

   logic        clock         = 1'b0;
   logic        reset         = 1'b1;
   logic        valid         = 1'b0;
   logic        ready;
   logic [1:0]  csr_index     = CSR_FROM_SYSTEM;
   logic [4:0]  csr_data      = 5'd0;
   logic        push          = 1'b0;
   logic        full;
   logic [1:0]  req_operation = OP_POSITION;
   logic [1:0]  req_band      = 2'd0;
   lane_vec_t   req_lanes     = '0;
   logic        empty;
   logic        pop           = 1'b0;
   value_type   rsp_result_0, rsp_result_1, rsp_result_2;
   value_type   rsp_result_3, rsp_result_4, rsp_result_5;
   value_type   rsp_result_6, rsp_result_7, rsp_result_8;
   lane_vec_t   rsp_lanes;

   // register copies used by the prediction
   logic [4:0]  cfg_from   = 5'd0;
   logic [4:0]  cfg_to     = 5'd0;
   logic [2:0]  cfg_degree = 3'd0;
   logic [4:0]  cfg_count  = 5'd24;

   lane_vec_t   converted_q[$];
   stim_row_t   directed_rows[$];
   int          failures    = 0;
   int          burst_left  = 0;
   int          quiet_count = 0;
   int          pop_mode    = 0;
   int          pop_tick    = 0;

   assign rsp_lanes = {rsp_result_8, rsp_result_7, rsp_result_6, rsp_result_5,
                       rsp_result_4, rsp_result_3, rsp_result_2, rsp_result_1,
                       rsp_result_0};

   axis_convention_converter_unit dut (
      .clock         (clock),
      .reset         (reset),
      .valid         (valid),
      .ready         (ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .push          (push),
      .full          (full),
      .req_operation (req_operation),
      .req_band      (req_band),
      .req_value_0   (req_lanes[0]),
      .req_value_1   (req_lanes[1]),
      .req_value_2   (req_lanes[2]),
      .req_value_3   (req_lanes[3]),
      .req_value_4   (req_lanes[4]),
      .req_value_5   (req_lanes[5]),
      .req_value_6   (req_lanes[6]),
      .req_value_7   (req_lanes[7]),
      .req_value_8   (req_lanes[8]),
      .empty         (empty),
      .pop           (pop),
      .rsp_result_0  (rsp_result_0),
      .rsp_result_1  (rsp_result_1),
      .rsp_result_2  (rsp_result_2),
      .rsp_result_3  (rsp_result_3),
      .rsp_result_4  (rsp_result_4),
      .rsp_result_5  (rsp_result_5),
      .rsp_result_6  (rsp_result_6),
      .rsp_result_7  (rsp_result_7),
      .rsp_result_8  (rsp_result_8)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp32(input longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
   endfunction

   function automatic longint negate_sat(input longint x);
      return clamp32(-x);
   endfunction

   // exact sum of two weighted terms, rounded half up, then clamped
   function automatic longint blend(input longint a, input longint wa,
                                    input longint b, input longint wb);
      longint acc;
      acc = a * wa + b * wb;
      return clamp32((acc + W_HALF) >>> 30);
   endfunction

   function automatic lane_vec_t convert_item(input logic [1:0] op, input logic [1:0] band,
                                              input lane_vec_t vin);
      longint    v[9];
      longint    r[9];
      longint    t0, t1, t2, t3, t4;
      logic      identity, rotate, back;
      logic [2:0] mis, qflip;
      logic [3:0] fm, tm;
      int        cnt, lim, start, size, bnd, idx;
      lane_vec_t res;
      for (int i = 0; i < 9; i++) begin
         v[i] = longint'($signed(vin[i]));
         r[i] = 0;
      end
      identity = (cfg_from == cfg_to) || (cfg_from == 5'd0) || (cfg_to == 5'd0);
      mis = 3'd0;
      rotate = 1'b0;
      back = 1'b0;
      if (!identity) begin
         // only the low four bits of code-1 matter
         fm = cfg_from[3:0] - 4'd1;
         tm = cfg_to[3:0] - 4'd1;
         mis = fm[2:0] ^ tm[2:0];
         rotate = fm[3] ^ tm[3];
         back = fm[3];
      end
      cnt = (cfg_count < 5'd24) ? int'(cfg_count) : 24;
      bnd = int'(band);
      case (op)
         OP_POSITION: begin
            for (int i = 0; i < 3; i++) r[i] = v[i];
            if (rotate && !back) begin
               t1 = r[1];
               r[1] = negate_sat(r[2]);
               r[2] = t1;
            end
            for (int i = 0; i < 3; i++) if (mis[i]) r[i] = negate_sat(r[i]);
            if (rotate && back) begin
               t1 = r[1];
               r[1] = r[2];
               r[2] = negate_sat(t1);
            end
         end
         OP_QUATERNION: begin
            qflip[0] = ^(mis & 3'b110);
            qflip[1] = ^(mis & 3'b101);
            qflip[2] = ^(mis & 3'b011);
            for (int i = 0; i < 4; i++) r[i] = v[i];
            if (rotate && !back) begin
               t0 = r[0]; t1 = r[1]; t2 = r[2]; t3 = r[3];
               r[0] = blend(t0, W_S2, t1, W_S2);
               r[1] = blend(t2, W_S2, t3, -W_S2);
               r[2] = blend(t2, W_S2, t3, W_S2);
               r[3] = blend(t0, W_S2, t1, -W_S2);
            end
            for (int i = 0; i < 3; i++) if (qflip[i]) r[i] = negate_sat(r[i]);
            if (rotate && back) begin
               t0 = r[0]; t1 = r[1]; t2 = r[2]; t3 = r[3];
               r[0] = blend(t0, -W_S2, t1, W_S2);
               r[1] = blend(t2, W_S2, t3, W_S2);
               r[2] = blend(t2, -W_S2, t3, W_S2);
               r[3] = blend(t0, W_S2, t1, W_S2);
            end
         end
         OP_SH_BAND: begin
            start = bnd * (bnd + 2);
            size = 2 * bnd + 3;
            for (int k = 0; k < size; k++) r[k] = v[k];
            if (rotate) begin
               lim = (cfg_degree < 3'd2) ? int'(cfg_degree) : 2;
               // bands out of reach or cut by the count pass through
               if (bnd < lim && start + size <= cnt) begin
                  if (bnd == 0) begin
                     t0 = r[0]; t1 = r[1];
                     r[0] = back ? negate_sat(t1) : t1;
                     r[1] = back ? t0 : negate_sat(t0);
                  end else begin
                     t0 = r[0]; t1 = r[1]; t2 = r[2]; t3 = r[3]; t4 = r[4];
                     r[0] = back ? negate_sat(t3) : t3;
                     r[1] = negate_sat(t1);
                     r[2] = blend(t2, -W_HALF, t4, -W_S3H);
                     r[3] = back ? t0 : negate_sat(t0);
                     r[4] = blend(t2, -W_S3H, t4, W_HALF);
                  end
               end
            end else begin
               for (int k = 0; k < size; k++) begin
                  idx = start + k;
                  if (idx < cnt && idx < 24 && ^(COEF_AXES[idx] & mis))
                     r[k] = negate_sat(r[k]);
               end
            end
         end
         default: ;
      endcase
      for (int i = 0; i < 9; i++) res[i] = r[i][31:0];
      return res;
   endfunction

   // ----------------------------------------------------------------- stimulus

   function automatic lane_vec_t lanes9(input logic [31:0] e0, e1, e2, e3, e4,
                                        input logic [31:0] e5, e6, e7, e8);
      return {e8, e7, e6, e5, e4, e3, e2, e1, e0};
   endfunction

   function automatic logic [31:0] random_value();
      int pick;
      pick = $urandom_range(0, 11);
      case (pick)
         0: return V_MAX;
         1: return V_MIN;
         2: return V_NEG1;
         3: return 32'($urandom_range(0, 2));
         4: return 32'(int'($urandom_range(0, 262143)) - 131072);
         default: return $urandom();
      endcase
   endfunction

   function automatic logic [4:0] random_code();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return 5'd0;
      if (pick == 1) return 5'($urandom_range(17, 31));
      return 5'($urandom_range(1, 16));
   endfunction

   task automatic add_row(input logic [4:0] f, input logic [4:0] t, input logic [2:0] d,
                          input logic [4:0] c, input logic [1:0] op, input logic [1:0] band,
                          input lane_vec_t v, input bit known, input lane_vec_t want);
      directed_rows.push_back('{f, t, d, c, op, band, v, known, want});
   endtask

   // sends one item inside the current burst, opening a new burst when due
   task automatic send_item(input logic [1:0] op, input logic [1:0] band, input lane_vec_t v,
                            input lane_vec_t want);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_operation <= op;
      req_band <= band;
      req_lanes <= v;
      push <= 1'b1;
      do @(posedge clock); while (full);
      converted_q.push_back(want);
      burst_left--;
   endtask

   task automatic drain();
      push <= 1'b0;
      while (converted_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic [1:0] index, input logic [4:0] data);
      valid <= 1'b1;
      csr_index <= index;
      csr_data <= data;
      do @(posedge clock); while (!ready);
   endtask

   task automatic set_config(input logic [4:0] f, input logic [4:0] t, input logic [2:0] d,
                             input logic [4:0] c);
      drain();
      write_csr(CSR_FROM_SYSTEM, f);
      write_csr(CSR_TO_SYSTEM, t);
      write_csr(CSR_SH_DEGREE, {2'd0, d});
      write_csr(CSR_COEFF_COUNT, c);
      valid <= 1'b0;
      cfg_from = f;
      cfg_to = t;
      cfg_degree = d;
      cfg_count = c;
   endtask

   initial begin : stimulus
      lane_vec_t vec_ext, vec_mix, vec_sat, vec_mid, v;
      stim_row_t row;
      logic [1:0] op;
      logic [1:0] band_pick;
      vec_ext = lanes9(V_MAX, V_MIN, 32'd1, V_NEG1, V_NEG1, V_NEG1, V_NEG1, V_NEG1, V_NEG1);
      vec_mix = lanes9(V_MIN, V_MAX, V_NEG1, 32'd12345, 32'h00018000, 32'hfffe8000,
                       32'd7, V_MAX, V_MIN);
      vec_sat = lanes9(V_MAX, V_MAX, V_MIN, V_MIN, V_NEG1, V_NEG1, V_NEG1, V_NEG1, V_NEG1);
      vec_mid = lanes9(32'h00010000, 32'hffff0000, 32'h00024000, 32'h12345678, 32'hedcba988,
                       32'h00008000, 32'h7fff0000, 32'h80010000, 32'd3);

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // pass-through after reset, unused operation
      add_row(0, 0, 0, 24, OP_POSITION, 2'd3, vec_ext, 1,
              lanes9(V_MAX, V_MIN, 32'd1, 0, 0, 0, 0, 0, 0));
      add_row(0, 0, 0, 24, OP_QUATERNION, 2'd2, vec_mix, 1,
              lanes9(V_MIN, V_MAX, V_NEG1, 32'd12345, 0, 0, 0, 0, 0));
      add_row(0, 0, 0, 24, OP_SH_BAND, 2'd3, vec_mix, 1, vec_mix);
      add_row(0, 0, 0, 24, OP_UNUSED, 2'd1, vec_ext, 1, '0);
      // equal codes, and an unspecified source code
      add_row(5, 5, 2, 24, OP_POSITION, 2'd0, vec_mid, 0, '0);
      add_row(0, 12, 2, 24, OP_SH_BAND, 2'd0, vec_mid, 0, '0);
      // sign flips only; negating the minimum saturates
      add_row(1, 2, 0, 24, OP_POSITION, 2'd0, vec_mix, 1,
              lanes9(V_MAX, V_MAX, V_NEG1, 0, 0, 0, 0, 0, 0));
      add_row(1, 2, 0, 24, OP_SH_BAND, 2'd1, vec_mid, 0, '0);
      add_row(1, 8, 0, 24, OP_POSITION, 2'd0, vec_ext, 1,
              lanes9(32'h80000001, V_MAX, V_NEG1, 0, 0, 0, 0, 0, 0));
      // forward rotation
      add_row(1, 9, 2, 24, OP_POSITION, 2'd0, vec_mid, 0, '0);
      add_row(1, 9, 2, 24, OP_QUATERNION, 2'd0, vec_sat, 0, '0);
      add_row(1, 9, 2, 24, OP_QUATERNION, 2'd0, vec_mid, 0, '0);
      add_row(1, 9, 2, 24, OP_SH_BAND, 2'd0, vec_sat, 0, '0);
      add_row(1, 9, 2, 24, OP_SH_BAND, 2'd1, vec_mid, 0, '0);
      add_row(1, 9, 2, 24, OP_SH_BAND, 2'd2, vec_mid, 0, '0);
      // rotation back with an x flip
      add_row(16, 7, 2, 24, OP_POSITION, 2'd0, vec_mid, 0, '0);
      add_row(16, 7, 2, 24, OP_QUATERNION, 2'd0, vec_mid, 0, '0);
      add_row(16, 7, 2, 24, OP_SH_BAND, 2'd0, vec_mid, 0, '0);
      add_row(16, 7, 2, 24, OP_SH_BAND, 2'd1, vec_sat, 0, '0);
      // codes above 16, degree one leaves band one alone
      add_row(17, 26, 1, 24, OP_POSITION, 2'd0, vec_mid, 0, '0);
      add_row(17, 26, 1, 24, OP_SH_BAND, 2'd1, vec_mid, 0, '0);
      // count extremes with flips
      add_row(3, 6, 7, 0, OP_SH_BAND, 2'd2, vec_mid, 0, '0);
      add_row(3, 6, 7, 31, OP_SH_BAND, 2'd3, vec_mix, 0, '0);
      // band cut short by the count, beside one that still fits
      add_row(2, 31, 2, 7, OP_SH_BAND, 2'd1, vec_mid, 0, '0);
      add_row(2, 31, 2, 7, OP_SH_BAND, 2'd0, vec_mid, 0, '0);
      add_row(3, 6, 1, 5, OP_SH_BAND, 2'd1, vec_mid, 0, '0);

      foreach (directed_rows[n]) begin
         row = directed_rows[n];
         if (row.from_code != cfg_from || row.to_code != cfg_to ||
             row.degree != cfg_degree || row.count != cfg_count)
            set_config(row.from_code, row.to_code, row.degree, row.count);
         send_item(row.op, row.band, row.v,
                   row.known ? row.want : convert_item(row.op, row.band, row.v));
      end

      for (int phase = 0; phase < RAND_PHASES; phase++) begin
         set_config(random_code(), random_code(), 3'($urandom_range(0, 7)),
                    ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31)) : 5'd24);
         repeat (PHASE_ITEMS) begin
            op = ($urandom_range(0, 19) == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
            band_pick = 2'($urandom_range(0, 3));
            for (int i = 0; i < 9; i++) v[i] = random_value();
            send_item(op, band_pick, v, convert_item(op, band_pick, v));
         end
      end

      drain();
      if (failures == 0) begin
         $display("tb_axis_convention_converter_unit: PASS");
      end else begin
         $display("tb_axis_convention_converter_unit: FAIL");
      end
      $finish;
   end

   // ------------------------------------------------------------ result side

   // pop pattern changes every so often: free flow, light, heavy, periodic
   always @(posedge clock) begin
      if (!reset) begin
         if (pop_tick == 0) begin
            pop_mode = $urandom_range(0, 3);
            pop_tick = $urandom_range(20, 200);
         end else begin
            pop_tick--;
         end
         case (pop_mode)
            0: pop <= 1'b1;
            1: pop <= ($urandom_range(0, 3) != 0);
            2: pop <= ($urandom_range(0, 3) == 0);
            default: pop <= (pop_tick % 3 == 0);
         endcase
      end
   end

   always @(posedge clock) begin : check_results
      lane_vec_t want;
      if (!reset && pop && !empty) begin
         if (converted_q.size() == 0) begin
            $error("result popped with no item outstanding");
            failures++;
         end else begin
            want = converted_q.pop_front();
            for (int i = 0; i < 9; i++) begin
               if (rsp_lanes[i] !== want[i]) begin
                  $error("result_%0d: expected %0d, got %0d", i, $signed(want[i]),
                         $signed(rsp_lanes[i]));
                  failures++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || (valid && ready)) begin
         quiet_count = 0;
      end else begin
         quiet_count++;
      end
      if (quiet_count >= QUIET_LIMIT) begin
         $display("tb_axis_convention_converter_unit: FAIL");
         $finish;
      end
   end

endmodule
